FILE: rtl/pcrc16_pkg.sv
// ----------------------------------------------------------------------------
// pcrc16_pkg: shared types and constants of the parametric CRC-16 engine
// Holds the configuration record, register indexes and reset values.
// ----------------------------------------------------------------------------
package pcrc16_pkg;

   localparam int CRC_WIDTH  = 16;
   localparam int BYTE_WIDTH = 8;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_POLYNOMIAL      = 3'd0,
      CSR_INITIAL_VALUE   = 3'd1,
      CSR_REFLECT_INPUT   = 3'd2,
      CSR_REFLECT_OUTPUT  = 3'd3,
      CSR_OUTPUT_XOR_MASK = 3'd4
   } csr_index_type;

   localparam logic [CRC_WIDTH-1:0] POLYNOMIAL_RESET = 16'h1021;
   localparam logic [CRC_WIDTH-1:0] INITIAL_RESET    = 16'h0000;
   localparam logic [CRC_WIDTH-1:0] XOR_MASK_RESET   = 16'h0000;

   typedef struct packed {
      logic [CRC_WIDTH-1:0] polynomial;
      logic [CRC_WIDTH-1:0] initial_value;
      logic                 reflect_input;
      logic                 reflect_output;
      logic [CRC_WIDTH-1:0] output_xor_mask;
   } crc_cfg_type;

   typedef struct packed {
      logic [CRC_WIDTH-1:0] final_crc;
      logic [CRC_WIDTH-1:0] raw_remainder;
   } crc_result_type;

endpackage

FILE: rtl/pcrc16_fold.sv
// ----------------------------------------------------------------------------
// pcrc16_fold: one-byte CRC-16 update and finalization
// Folds a byte into the remainder in eight MSB-first steps, then finalizes.
// ----------------------------------------------------------------------------
module pcrc16_fold (
   input  pcrc16_pkg::crc_cfg_type              cfg,
   input  logic [pcrc16_pkg::CRC_WIDTH-1:0]     remainder,
   input  logic                                 start_of_message,
   input  logic [pcrc16_pkg::BYTE_WIDTH-1:0]    data_byte,
   output pcrc16_pkg::crc_result_type           result
);
   import pcrc16_pkg::*;

   logic [CRC_WIDTH-1:0]  rem_start;
   logic [BYTE_WIDTH-1:0] byte_in;
   logic [CRC_WIDTH-1:0]  rem_folded;
   logic [CRC_WIDTH-1:0]  rem_out;

   always_comb begin
      rem_start = start_of_message ? cfg.initial_value : remainder;

      for (int k = 0; k < BYTE_WIDTH; k++) begin
         byte_in[k] = cfg.reflect_input ? data_byte[BYTE_WIDTH-1-k] : data_byte[k];
      end

      // Each step feeds back the top remainder bit against the next data bit.
      rem_folded = rem_start;
      for (int k = BYTE_WIDTH-1; k >= 0; k--) begin
         if (rem_folded[CRC_WIDTH-1] ^ byte_in[k]) begin
            rem_folded = {rem_folded[CRC_WIDTH-2:0], 1'b0} ^ cfg.polynomial;
         end else begin
            rem_folded = {rem_folded[CRC_WIDTH-2:0], 1'b0};
         end
      end

      for (int k = 0; k < CRC_WIDTH; k++) begin
         rem_out[k] = cfg.reflect_output ? rem_folded[CRC_WIDTH-1-k] : rem_folded[k];
      end

      result.raw_remainder = rem_folded;
      result.final_crc     = rem_out ^ cfg.output_xor_mask;
   end

endmodule

FILE: rtl/parametric_crc16_engine.sv
// ----------------------------------------------------------------------------
// parametric_crc16_engine: byte-serial CRC-16 in the parametric model
// Configurable polynomial, initial value, reflections and output mask.
// ----------------------------------------------------------------------------
// Path: an accepted request word is registered in the request stage, then in the response stage.
// Throughput: one byte per cycle while the response side does not stall; the
// eight-step fold is combinational between the request and response registers.
// Reset (synchronous, active high) empties both stages, clears the running
// remainder to zero and restores the default configuration.
// ----------------------------------------------------------------------------
module parametric_crc16_engine (
   input  logic        clock,
   input  logic        reset,

   // Request stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] start_of_message

   // Response stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] raw_remainder, [31:16] final_crc

   // Configuration write port.
   input  logic                                    csr_we,
   input  logic [pcrc16_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [pcrc16_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   import pcrc16_pkg::*;

   // Configuration registers.
   crc_cfg_type cfg_ff, cfg_in;

   // Request stage: the accepted word waits here for one fold.
   logic                  req_valid_ff, req_valid_in;
   logic [BYTE_WIDTH-1:0] req_byte_ff, req_byte_in;
   logic                  req_start_ff, req_start_in;

   // Running remainder, advanced once per word that leaves the request stage.
   logic [CRC_WIDTH-1:0]  remainder_ff, remainder_in;

   // Response stage.
   logic                  rsp_valid_ff, rsp_valid_in;
   crc_result_type        rsp_data_ff, rsp_data_in;

   crc_result_type        fold_result;
   logic                  rsp_open;
   logic                  advance;

   // The response register can take a word when it is empty or being drained.
   assign rsp_open   = !rsp_valid_ff || rsp_tready;
   assign advance    = req_valid_ff && rsp_open;
   assign req_tready = !req_valid_ff || rsp_open;

   pcrc16_fold u_fold (
      .cfg              (cfg_ff),
      .remainder        (remainder_ff),
      .start_of_message (req_start_ff),
      .data_byte        (req_byte_ff),
      .result           (fold_result)
   );

   // Configuration decode; writes to unused indexes fall through unchanged.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_POLYNOMIAL:      cfg_in.polynomial      = csr_wdata;
            CSR_INITIAL_VALUE:   cfg_in.initial_value   = csr_wdata;
            CSR_REFLECT_INPUT:   cfg_in.reflect_input   = csr_wdata[0];
            CSR_REFLECT_OUTPUT:  cfg_in.reflect_output  = csr_wdata[0];
            CSR_OUTPUT_XOR_MASK: cfg_in.output_xor_mask = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      req_valid_in = req_valid_ff;
      req_byte_in  = req_byte_ff;
      req_start_in = req_start_ff;
      if (req_tready) begin
         req_valid_in = req_tvalid;
         req_byte_in  = req_tdata;
         req_start_in = req_tuser;
      end

      remainder_in = remainder_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (advance) begin
         remainder_in = fold_result.raw_remainder;
         rsp_data_in  = fold_result;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.polynomial      <= POLYNOMIAL_RESET;
         cfg_ff.initial_value   <= INITIAL_RESET;
         cfg_ff.reflect_input   <= 1'b0;
         cfg_ff.reflect_output  <= 1'b0;
         cfg_ff.output_xor_mask <= XOR_MASK_RESET;
         req_valid_ff           <= 1'b0;
         rsp_valid_ff           <= 1'b0;
         remainder_ff           <= '0;
      end else begin
         cfg_ff       <= cfg_in;
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         remainder_ff <= remainder_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      req_byte_ff  <= req_byte_in;
      req_start_ff <= req_start_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_data_ff.final_crc, rsp_data_ff.raw_remainder};

`ifndef SYNTHESIS
   // A full request stage behind a stalled response must hold off the source.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("request accepted while both stages are blocked");

   // Every word that leaves the request stage shows up as a response.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("folded word did not reach the response register");

   // The remainder moves only together with a word going to the response side.
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(remainder_ff))
      else $error("remainder changed without a folded word");

   // A pending response always reports the current running remainder.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.raw_remainder == remainder_ff))
      else $error("response remainder out of step with running remainder");
`endif

endmodule
